[hdl/assert_macros.svh]
// assertion macros used by the lexer top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every rising clock edge outside reset
`define ETL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define ETL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/etl_pkg.sv]
// shared types and constants of the expression token lexer
package etl_pkg;

  localparam int unsigned POS_BITS_DEF = 16;
  localparam int unsigned MAX_RESULTS  = 3;
  localparam int unsigned RES_DEPTH    = 4;

  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_EQUAL   = 4'd2,
    KIND_PLUS    = 4'd3,
    KIND_MINUS   = 4'd4,
    KIND_STAR    = 4'd5,
    KIND_SLASH   = 4'd6,
    KIND_LPAREN  = 4'd7,
    KIND_RPAREN  = 4'd8,
    KIND_UNKNOWN = 4'd9,
    KIND_EOF     = 4'd10
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [7:0]  first;
    logic        last;
  } result_t;

  // results of one item, packed in order, count in n
  typedef struct packed {
    logic [1:0]          n;
    result_t [MAX_RESULTS-1:0] res;
  } push_t;

endpackage

[hdl/etl_if.sv]
// handshake channels for source bytes and tokens
interface etl_char_if ();
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, char_valid, char_in, end_of_input, input ready);
  modport sink (input valid, char_valid, char_in, end_of_input, output ready);
endinterface

interface etl_token_if ();
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_pos;
  logic [15:0] token_length;
  logic [7:0]  first_char;
  logic        last_of_run;

  modport source (output valid, token_kind, start_pos, token_length, first_char,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, start_pos, token_length, first_char,
                last_of_run, output ready);
endinterface

[hdl/etl_core.sv]
// scanner state and token generation for one byte per cycle while fire_i is high
module etl_core import etl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic       char_valid_i,
  input  logic [7:0] char_in_i,
  input  logic       end_of_input_i,
  output push_t      push_o
);

  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'b001,
    MODE_IDENT  = 3'b010,
    MODE_NUMBER = 3'b100
  } mode_e;

  mode_e               mode_q, mode_d, mid_mode;
  logic [15:0]         start_q, start_d, mid_start;
  logic [15:0]         len_q, len_d, mid_len;
  logic [7:0]          first_q, first_d, mid_first;
  logic [POS_BITS-1:0] pos_q, pos_d, mid_pos;

  logic       byte_in, eoi, letter, digit, space, word, extend;
  logic [3:0] en;
  result_t    cand [4];
  result_t [MAX_RESULTS-1:0] slots;
  logic [2:0] n;

  function automatic kind_e op_kind(logic [7:0] c);
    kind_e k;
    case (c)
      CH_EQUAL:  k = KIND_EQUAL;
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  assign byte_in = fire_i & char_valid_i;
  assign eoi     = fire_i & end_of_input_i;
  assign letter  = (char_in_i >= 8'h61 && char_in_i <= 8'h7A) ||
                   (char_in_i >= 8'h41 && char_in_i <= 8'h5A);
  assign digit   = char_in_i >= 8'h30 && char_in_i <= 8'h39;
  assign space   = char_in_i == 8'h20 || (char_in_i >= 8'h09 && char_in_i <= 8'h0D);
  assign word    = letter | digit | (char_in_i == CH_UNDER);
  assign extend  = byte_in && ((mode_q == MODE_IDENT && word) ||
                               (mode_q == MODE_NUMBER && digit));

  // state once the byte is taken, before the end mark
  always_comb begin
    mid_mode  = mode_q;
    mid_start = start_q;
    mid_len   = len_q;
    mid_first = first_q;
    mid_pos   = pos_q;
    if (byte_in) begin
      mid_pos = pos_q + 1'b1;
      if (extend) begin
        mid_len = (len_q == 16'hFFFF) ? len_q : len_q + 16'd1;
      end else if (space || !(letter || digit || char_in_i == CH_UNDER)) begin
        mid_mode = MODE_IDLE;
      end else begin
        mid_mode  = digit ? MODE_NUMBER : MODE_IDENT;
        mid_start = 16'(pos_q);
        mid_len   = 16'd1;
        mid_first = char_in_i;
      end
    end
  end

  // candidate results in emission order
  always_comb begin
    en[0] = byte_in && !extend && (mode_q == MODE_IDENT || mode_q == MODE_NUMBER);
    cand[0] = '{kind: (mode_q == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                start: start_q, length: len_q, first: first_q, last: 1'b0};
    en[1] = byte_in && !extend && !space && !word;
    cand[1] = '{kind: op_kind(char_in_i), start: 16'(pos_q), length: 16'd1,
                first: char_in_i, last: 1'b0};
    en[2] = eoi && (mid_mode == MODE_IDENT || mid_mode == MODE_NUMBER);
    cand[2] = '{kind: (mid_mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                start: mid_start, length: mid_len, first: mid_first, last: 1'b0};
    en[3] = eoi;
    cand[3] = '{kind: KIND_EOF, start: 16'(mid_pos), length: 16'd0,
                first: 8'd0, last: 1'b0};
  end

  // pack enabled candidates into consecutive slots, at most three are ever set
  always_comb begin
    slots = '0;
    n     = 3'd0;
    for (int k = 0; k < 4; k++) begin
      if (en[k] && n < 3'(MAX_RESULTS)) begin
        slots[n[1:0]] = cand[k];
        n = n + 3'd1;
      end
    end
    if (n != 3'd0) begin
      slots[2'(n - 3'd1)].last = 1'b1;
    end
  end

  assign push_o.n   = n[1:0];
  assign push_o.res = slots;

  always_comb begin
    mode_d  = mid_mode;
    start_d = mid_start;
    len_d   = mid_len;
    first_d = mid_first;
    pos_d   = mid_pos;
    if (eoi) begin
      mode_d  = MODE_IDLE;
      start_d = '0;
      len_d   = '0;
      first_d = '0;
      pos_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      len_q   <= '0;
      first_q <= '0;
      pos_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      start_q <= start_d;
      len_q   <= len_d;
      first_q <= first_d;
      pos_q   <= pos_d;
    end
  end

endmodule

[hdl/etl_res_fifo.sv]
// result queue taking up to three tokens per cycle and giving one
module etl_res_fifo import etl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output result_t head_o,
  output logic    head_valid_o,
  output logic [$clog2(RES_DEPTH+1)-1:0] count_o
);

  localparam int unsigned PtrW = $clog2(RES_DEPTH);
  localparam int unsigned CntW = $clog2(RES_DEPTH+1);

  result_t         mem_q [RES_DEPTH];
  logic [PtrW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop     = pop_i & (cnt_q != '0);
  assign wp_d    = wp_q + PtrW'(push_i.n);
  assign rp_d    = rp_q + PtrW'(pop);
  assign cnt_d   = cnt_q + CntW'(push_i.n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_i.n) begin
        mem_q[wp_q + PtrW'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  assign head_o       = mem_q[rp_q];
  assign head_valid_o = cnt_q != '0;
  assign count_o      = cnt_q;

endmodule

[hdl/expression_token_lexer_unit.sv]
// expression token lexer: one byte per cycle while ready, first token in the next cycle
// throughput: one item per cycle while each item gives at most one token
// an item giving two or three tokens stalls input until the 4-entry queue drains to one
// input ready needs room for three tokens, so a stalled output holds the input back
// reset is asynchronous active low: scanner idle, position 0, result queue empty
`include "assert_macros.svh"

module expression_token_lexer_unit import etl_pkg::*; #(
  parameter int unsigned POS_BITS = POS_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  etl_char_if.sink           char_i,
  etl_token_if.source        token_o
);

  localparam int unsigned CntW = $clog2(RES_DEPTH+1);

  logic            fire;
  push_t           push;
  result_t         head;
  logic            head_valid;
  logic [CntW-1:0] count;

  assign char_i.ready = count <= CntW'(RES_DEPTH - MAX_RESULTS);
  assign fire         = char_i.valid & char_i.ready;

  etl_core #(
    .POS_BITS(POS_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .char_valid_i   (char_i.char_valid),
    .char_in_i      (char_i.char_in),
    .end_of_input_i (char_i.end_of_input),
    .push_o         (push)
  );

  etl_res_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .pop_i        (token_o.ready),
    .head_o       (head),
    .head_valid_o (head_valid),
    .count_o      (count)
  );

  assign token_o.valid        = head_valid;
  assign token_o.token_kind   = head.kind;
  assign token_o.start_pos    = head.start;
  assign token_o.token_length = head.length;
  assign token_o.first_char   = head.first;
  assign token_o.last_of_run  = head.last;

  `ETL_ASSERT(a_fifo_bound, clk_i, rst_ni, count <= CntW'(RES_DEPTH), "result queue overflow")
  `ETL_ASSERT_IMP(a_no_phantom, clk_i, rst_ni, !fire, push.n == 2'd0, "token without item")
  `ETL_ASSERT_IMP(a_eof_emitted, clk_i, rst_ni, fire && char_i.end_of_input,
                  push.n != 2'd0, "end mark gave no token")

endmodule

[verif/tb_expression_token_lexer_unit.sv]
// testbench for the expression token lexer: directed and random byte streams checked token by token
module tb_expression_token_lexer_unit;
  import etl_pkg::*;

  localparam int unsigned POS_W        = POS_BITS_DEF;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 228;
  localparam int unsigned LONG_IDENT   = 12;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_IDENT  = 2'd1,
    SCAN_NUMBER = 2'd2
  } scan_e;

  class token_ledger;
    scan_e            mode;
    logic [15:0]      open_start;
    logic [15:0]      open_len;
    logic [7:0]       open_first;
    logic [POS_W-1:0] next_pos;
    result_t          due[$];
    int               mismatches;

    function new();
      clear_scan();
      mismatches = 0;
    endfunction

    function void clear_scan();
      mode       = SCAN_IDLE;
      open_start = '0;
      open_len   = '0;
      open_first = '0;
      next_pos   = '0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function kind_e op_kind(logic [7:0] c);
      case (c)
        "=": return KIND_EQUAL;
        "+": return KIND_PLUS;
        "-": return KIND_MINUS;
        "*": return KIND_STAR;
        "/": return KIND_SLASH;
        "(": return KIND_LPAREN;
        ")": return KIND_RPAREN;
        default: return KIND_UNKNOWN;
      endcase
    endfunction

    function void push_token(kind_e k, logic [15:0] s, logic [15:0] len, logic [7:0] f);
      result_t r;
      r.kind   = k;
      r.start  = s;
      r.length = len;
      r.first  = f;
      r.last   = 1'b0;
      due.insert(due.size(), r);
    endfunction

    function void close_open();
      if (mode == SCAN_IDENT) begin
        push_token(KIND_IDENT, open_start, open_len, open_first);
      end else if (mode == SCAN_NUMBER) begin
        push_token(KIND_NUMBER, open_start, open_len, open_first);
      end
      mode = SCAN_IDLE;
    endfunction

    function void open_token(scan_e m, logic [7:0] c);
      mode       = m;
      open_start = 16'(next_pos);
      open_len   = 16'd1;
      open_first = c;
    endfunction

    // predict the tokens caused by one accepted item
    function void note_item(bit cv, logic [7:0] c, bit eoi);
      int first_new;
      bit word;
      first_new = due.size();
      if (cv) begin
        word = is_letter(c) || is_digit(c) || c == "_";
        if ((mode == SCAN_IDENT && word) || (mode == SCAN_NUMBER && is_digit(c))) begin
          if (open_len != 16'hFFFF) open_len++;
        end else begin
          close_open();
          // whitespace only closes the open token
          if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
            if (is_letter(c) || c == "_") begin
              open_token(SCAN_IDENT, c);
            end else if (is_digit(c)) begin
              open_token(SCAN_NUMBER, c);
            end else begin
              push_token(op_kind(c), 16'(next_pos), 16'd1, c);
            end
          end
        end
        next_pos++;
      end
      if (eoi) begin
        close_open();
        push_token(KIND_EOF, 16'(next_pos), 16'd0, 8'd0);
        clear_scan();
      end
      if (due.size() > first_new) due[due.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_token(logic [3:0] kind, logic [15:0] s, logic [15:0] len,
                              logic [7:0] f, logic last);
      result_t want;
      if (due.size() == 0) begin
        $error("token with nothing pending: kind %0d start %0d", kind, s);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("token_kind", want.kind, kind);
      compare_field("start_pos", want.start, s);
      compare_field("token_length", want.length, len);
      compare_field("first_char", want.first, f);
      compare_field("last_of_run", want.last, last);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  bit          calm;
  int unsigned items_sent;
  int unsigned idle_cycles = 0;
  token_ledger ledger = new();

  etl_char_if  src_if ();
  etl_token_if tok_if ();

  expression_token_lexer_unit #(.POS_BITS(POS_W)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (src_if),
    .token_o (tok_if)
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = ($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41;
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return rand_digit();
    return "_";
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(bit cv, logic [7:0] c, bit eoi);
    int idle;
    idle = pick_gap();
    if (idle > 0) begin
      src_if.valid <= 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    src_if.valid        <= 1'b1;
    src_if.char_valid   <= cv;
    src_if.char_in      <= c;
    src_if.end_of_input <= eoi;
    @(posedge clk_i);
    while (!src_if.ready) @(posedge clk_i);
    ledger.note_item(cv, c, eoi);
    if (cv || eoi) items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit eoi_last);
    for (int i = 0; i < s.len(); i++) send_item(1'b1, s[i], eoi_last && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    src_if.valid <= 1'b0;
    do @(negedge clk_i); while (ledger.pending() != 0);
  endtask

  // mostly well-formed tokens, some odd bytes, end marks and empty items
  task automatic send_fragment();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      send_item(1'b1, ($urandom_range(0, 4) == 0) ? 8'h5F : rand_letter(), 1'b0);
      repeat ($urandom_range(0, 5)) send_item(1'b1, rand_word_char(), 1'b0);
    end else if (pick < 46) begin
      repeat ($urandom_range(1, 5)) send_item(1'b1, rand_digit(), 1'b0);
    end else if (pick < 66) begin
      case ($urandom_range(0, 6))
        0: c = "=";
        1: c = "+";
        2: c = "-";
        3: c = "*";
        4: c = "/";
        5: c = "(";
        default: c = ")";
      endcase
      send_item(1'b1, c, 1'b0);
    end else if (pick < 80) begin
      c = ($urandom_range(0, 1) != 0) ? 8'h20 : 8'($urandom_range(9, 13));
      send_item(1'b1, c, 1'b0);
    end else if (pick < 88) begin
      case ($urandom_range(0, 3))
        0: c = 8'($urandom_range(128, 255));
        1: c = 8'($urandom_range(0, 8));
        2: c = 8'($urandom_range(14, 31));
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_item(1'b1, c, 1'b0);
    end else if (pick < 96) begin
      c = ($urandom_range(0, 1) != 0) ? rand_word_char() : 8'($urandom_range(32, 47));
      send_item($urandom_range(0, 2) != 0, c, 1'b1);
      calm = ($urandom_range(0, 3) == 0);
    end else begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    tok_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold > 0) hold--;
      else hold = pick_gap();
      tok_if.ready <= (hold == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      ledger.check_token(tok_if.token_kind, tok_if.start_pos, tok_if.token_length,
                         tok_if.first_char, tok_if.last_of_run);
    end
  end

  always @(posedge clk_i) begin
    if ((src_if.valid && src_if.ready) || (tok_if.valid && tok_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned start_count;
    bit drained_mid;
    rst_ni              = 1'b0;
    src_if.valid        = 1'b0;
    src_if.char_valid   = 1'b0;
    src_if.char_in      = 8'd0;
    src_if.end_of_input = 1'b0;
    calm                = 1'b0;
    items_sent          = 0;
    drained_mid         = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // every operator, every whitespace byte, tokens closed by operators
    send_text("_x9 =\t(12\n+Zb\v)*\f3/\015-", 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    // open identifier, operator and end mark in one item: three tokens
    send_item(1'b1, "k", 1'b0);
    send_item(1'b1, "+", 1'b1);
    send_item(1'b0, 8'h00, 1'b0);
    send_item(1'b0, 8'hA5, 1'b1);
    send_item(1'b1, " ", 1'b1);
    wait_drained();

    // longer identifier closed by an operator, then a number flushed by the end mark
    calm = 1'b1;
    send_item(1'b1, "L", 1'b0);
    repeat (LONG_IDENT - 1) send_item(1'b1, rand_word_char(), 1'b0);
    send_item(1'b1, ")", 1'b0);
    send_item(1'b1, "5", 1'b1);
    calm = 1'b0;

    start_count = items_sent;
    while (items_sent < start_count + RANDOM_ITEMS) begin
      send_fragment();
      if (!drained_mid && items_sent >= start_count + RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
    end
    wait_drained();
    repeat (8) @(negedge clk_i);

    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
